// ----- design/rrd_pkg.sv -----
`timescale 1ns / 1ps
package rrd_pkg;

	localparam int SEEN_DEPTH_DEF    = 32;
	localparam int REVERSE_DEPTH_DEF = 16;

	localparam logic [7:0]  MIN_PAYLOAD = 8'd21;
	localparam logic [4:0]  MAX_TTL     = 5'd31;
	localparam logic [31:0] SEEN_TTL_RST = 32'd30000;
	localparam logic [31:0] REV_TTL_RST  = 32'd60000;

	localparam logic CFG_SEEN_TTL = 1'b0;
	localparam logic CFG_REV_TTL  = 1'b1;

	typedef enum logic [2:0] {
		ACT_SHORT   = 3'd0,
		ACT_DUP     = 3'd1,
		ACT_REPLY   = 3'd2,
		ACT_FORWARD = 3'd3,
		ACT_LOCAL   = 3'd4,
		ACT_NOREV   = 3'd5,
		ACT_RELAY   = 3'd6
	} act_t;

	// Broadcast to every seen cell for the whole pass.
	typedef struct packed {
		logic        wr_free;
		logic [63:0] orig;
		logic [31:0] req;
		logic [63:0] tgt;
		logic [31:0] now;
		logic [31:0] ttl;
	} seen_cmd_t;

	// Token that walks the seen chain one cell per cycle.
	typedef struct packed {
		logic        active;
		logic        fill;
		logic        hit;
		logic        live;
		logic        free_found;
		logic        have_old;
		logic        done;
		logic [31:0] old_time;
	} seen_tok_t;

	typedef struct packed {
		logic        wr_free;
		logic        wr_zero;
		logic        clr_hit;
		logic [63:0] orig;
		logic [31:0] req;
		logic [63:0] prev;
		logic [31:0] now;
		logic [31:0] ttl;
	} rev_cmd_t;

	typedef struct packed {
		logic        active;
		logic        hit;
		logic        live;
		logic        free_found;
		logic [63:0] prev_hop;
	} rev_tok_t;

endpackage

// ----- design/rrd_in_if.sv -----
`timescale 1ns / 1ps
interface rrd_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] now_ms;
	logic [63:0] from_id;
	logic [63:0] target_id;
	logic [31:0] req_id;
	logic [7:0]  hop_count;
	logic [63:0] peer_id;
	logic [7:0]  payload_len;
	logic        for_me;

	modport source (output valid, func, now_ms, from_id, target_id, req_id, hop_count,
		peer_id, payload_len, for_me, input ready);
	modport sink (input valid, func, now_ms, from_id, target_id, req_id, hop_count,
		peer_id, payload_len, for_me, output ready);
endinterface

// ----- design/rrd_out_if.sv -----
`timescale 1ns / 1ps
interface rrd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] dest_id;
	logic [7:0]  hop_count_out;
	logic [4:0]  forward_ttl;
	logic [63:0] origin_id;

	modport source (output valid, action, dest_id, hop_count_out, forward_ttl, origin_id,
		input ready);
	modport sink (input valid, action, dest_id, hop_count_out, forward_ttl, origin_id,
		output ready);
endinterface

// ----- design/rrd_cfg_if.sv -----
`timescale 1ns / 1ps
interface rrd_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/route_request_dedup_reverse_path_top.sv -----
`timescale 1ns / 1ps
// Route request duplicate cache and reverse-path table.
// The request channel carries one received route request or route reply per item;
// the result channel returns exactly one item per request item, in order. The cfg
// channel writes the seen lifetime (index 0) and the reverse lifetime (index 1); it
// is always ready. The user must write it only while the block is idle; the block
// itself does not enforce this. Each table is a chain of cells, one entry per cell.
// A lookup token enters the first cell and moves one cell per cycle. A short payload
// or a local reply uses neither table. A duplicate or a reply to the sender takes a
// seen pass, a forwarded request a seen pass and then a reverse pass; when the seen
// cache is full a second seen pass replaces the oldest entry. A relayed reply takes a
// reverse pass. One item is in work at a time.
// The finished result sits in an output register; a new item can be accepted while
// it waits, but the next result waits until the receiver takes the current one.
// Reset empties both tables, sets the lifetimes to 30000 and 60000 ms and drops
// any result not yet taken.
module route_request_dedup_reverse_path_top #(
	parameter int SEEN_DEPTH    = rrd_pkg::SEEN_DEPTH_DEF,
	parameter int REVERSE_DEPTH = rrd_pkg::REVERSE_DEPTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	rrd_in_if.sink  request,
	rrd_out_if.source result,
	rrd_cfg_if.sink cfg
);
	import rrd_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SEEN, S_FILL, S_REV, S_FIN} state_t;

	state_t      state_q;
	logic [31:0] seen_ttl_q;
	logic [31:0] rev_ttl_q;

	logic        func_q;
	logic [31:0] now_q;
	logic [63:0] from_q;
	logic [63:0] target_q;
	logic [31:0] req_q;
	logic [7:0]  hop_q;
	logic [63:0] peer_q;
	logic        for_me_q;

	logic        seen_go_q;
	logic        fill_go_q;
	logic [31:0] old_time_q;
	logic        seen_wr_q;
	logic        rev_go_q;
	logic        rev_wr_free_q;
	logic        rev_wr_zero_q;
	logic        rev_clr_q;

	act_t        res_act_q;
	logic [63:0] res_dest_q;
	logic [7:0]  res_hop_q;
	logic [4:0]  res_ttl_q;

	logic        out_valid_q;
	logic [2:0]  out_act_q;
	logic [63:0] out_dest_q;
	logic [7:0]  out_hop_q;
	logic [4:0]  out_ttl_q;
	logic [63:0] out_origin_q;

	seen_cmd_t   seen_cmd;
	rev_cmd_t    rev_cmd;
	seen_tok_t   seen_link [SEEN_DEPTH+1];
	rev_tok_t    rev_link [REVERSE_DEPTH+1];
	seen_tok_t   seen_end;
	rev_tok_t    rev_end;

	logic        accept;
	logic [7:0]  hop_plus;
	logic [8:0]  new_hops;
	logic [4:0]  fwd_ttl;

	assign accept   = request.valid && request.ready;
	assign hop_plus = hop_q + 8'd1;
	assign new_hops = {1'b0, hop_q} + 9'd1;
	assign fwd_ttl  = (new_hops >= {4'd0, MAX_TTL}) ? 5'd0 : 5'({4'd0, MAX_TTL} - new_hops);

	assign request.ready = state_q == S_IDLE;
	assign cfg.ready     = 1'b1;

	assign result.valid         = out_valid_q;
	assign result.action        = out_act_q;
	assign result.dest_id       = out_dest_q;
	assign result.hop_count_out = out_hop_q;
	assign result.forward_ttl   = out_ttl_q;
	assign result.origin_id     = out_origin_q;

	always_comb begin
		seen_cmd.wr_free = seen_wr_q;
		seen_cmd.orig    = from_q;
		seen_cmd.req     = req_q;
		seen_cmd.tgt     = target_q;
		seen_cmd.now     = now_q;
		seen_cmd.ttl     = seen_ttl_q;

		rev_cmd.wr_free = rev_wr_free_q;
		rev_cmd.wr_zero = rev_wr_zero_q;
		rev_cmd.clr_hit = rev_clr_q;
		rev_cmd.orig    = func_q ? peer_q : from_q;
		rev_cmd.req     = req_q;
		rev_cmd.prev    = peer_q;
		rev_cmd.now     = now_q;
		rev_cmd.ttl     = rev_ttl_q;

		seen_link[0]          = '0;
		seen_link[0].active   = seen_go_q | fill_go_q;
		seen_link[0].fill     = fill_go_q;
		seen_link[0].old_time = old_time_q;

		rev_link[0]        = '0;
		rev_link[0].active = rev_go_q;
	end

	assign seen_end = seen_link[SEEN_DEPTH];
	assign rev_end  = rev_link[REVERSE_DEPTH];

	for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_seen
		rrd_seen_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (seen_cmd),
			.tok_in  (seen_link[i]),
			.tok_out (seen_link[i+1])
		);
	end

	for (genvar i = 0; i < REVERSE_DEPTH; i++) begin : g_rev
		rrd_rev_cell #(.IS_SLOT0(i == 0)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (rev_cmd),
			.tok_in  (rev_link[i]),
			.tok_out (rev_link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ttl_q <= SEEN_TTL_RST;
			rev_ttl_q  <= REV_TTL_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_SEEN_TTL: seen_ttl_q <= cfg.data;
				CFG_REV_TTL:  rev_ttl_q  <= cfg.data;
				default:      seen_ttl_q <= seen_ttl_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= request.func;
			now_q    <= request.now_ms;
			from_q   <= request.from_id;
			target_q <= request.target_id;
			req_q    <= request.req_id;
			hop_q    <= request.hop_count;
			peer_q   <= request.peer_id;
			for_me_q <= request.for_me;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			seen_go_q     <= 1'b0;
			fill_go_q     <= 1'b0;
			old_time_q    <= '0;
			seen_wr_q     <= 1'b0;
			rev_go_q      <= 1'b0;
			rev_wr_free_q <= 1'b0;
			rev_wr_zero_q <= 1'b0;
			rev_clr_q     <= 1'b0;
			res_act_q     <= ACT_SHORT;
			res_dest_q    <= '0;
			res_hop_q     <= '0;
			res_ttl_q     <= MAX_TTL;
			out_valid_q   <= 1'b0;
			out_act_q     <= '0;
			out_dest_q    <= '0;
			out_hop_q     <= '0;
			out_ttl_q     <= '0;
			out_origin_q  <= '0;
		end else begin
			seen_go_q     <= 1'b0;
			fill_go_q     <= 1'b0;
			seen_wr_q     <= 1'b0;
			rev_go_q      <= 1'b0;
			rev_wr_free_q <= 1'b0;
			rev_wr_zero_q <= 1'b0;
			rev_clr_q     <= 1'b0;
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_dest_q <= '0;
						res_hop_q  <= '0;
						res_ttl_q  <= MAX_TTL;
						if (request.payload_len < MIN_PAYLOAD) begin
							res_act_q <= ACT_SHORT;
							state_q   <= S_FIN;
						end else if (!request.func) begin
							seen_go_q <= 1'b1;
							state_q   <= S_SEEN;
						end else if (request.for_me) begin
							res_act_q <= ACT_LOCAL;
							state_q   <= S_FIN;
						end else begin
							rev_go_q <= 1'b1;
							state_q  <= S_REV;
						end
					end
				end
				S_SEEN, S_FILL: begin
					if (seen_end.active) begin
						if (state_q == S_SEEN && seen_end.hit && seen_end.live) begin
							res_act_q <= ACT_DUP;
							state_q   <= S_FIN;
						end else if (state_q == S_SEEN && !seen_end.free_found) begin
							// Cache full: a second pass replaces the first oldest entry.
							old_time_q <= seen_end.old_time;
							fill_go_q  <= 1'b1;
							state_q    <= S_FILL;
						end else begin
							seen_wr_q <= state_q == S_SEEN;
							res_hop_q <= hop_plus;
							if (for_me_q) begin
								res_act_q  <= ACT_REPLY;
								res_dest_q <= peer_q;
								state_q    <= S_FIN;
							end else begin
								rev_go_q <= 1'b1;
								state_q  <= S_REV;
							end
						end
					end
				end
				S_REV: begin
					if (rev_end.active) begin
						state_q <= S_FIN;
						if (!func_q) begin
							res_act_q <= ACT_FORWARD;
							res_ttl_q <= fwd_ttl;
							if (!(rev_end.hit && rev_end.live)) begin
								rev_wr_free_q <= rev_end.free_found;
								rev_wr_zero_q <= !rev_end.free_found;
							end
						end else if (rev_end.hit && rev_end.live) begin
							res_act_q  <= ACT_RELAY;
							res_dest_q <= rev_end.prev_hop;
							res_hop_q  <= hop_q;
							rev_clr_q  <= 1'b1;
						end else begin
							res_act_q <= ACT_NOREV;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_act_q    <= res_act_q;
						out_dest_q   <= res_dest_q;
						out_hop_q    <= res_hop_q;
						out_ttl_q    <= res_ttl_q;
						out_origin_q <= from_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- design/rrd_seen_cell.sv -----
`timescale 1ns / 1ps
module rrd_seen_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rrd_pkg::seen_cmd_t cmd,
	input  rrd_pkg::seen_tok_t tok_in,
	output rrd_pkg::seen_tok_t tok_out
);
	import rrd_pkg::*;

	logic        valid_q;
	logic [63:0] orig_q;
	logic [31:0] req_q;
	logic [63:0] tgt_q;
	logic [31:0] time_q;
	logic        free_mark_q;
	seen_tok_t   tok_q;

	logic [31:0] age;
	logic        expired;
	logic        match;
	logic        scan;
	logic        first;
	logic        is_free;
	logic        fill_hit;
	logic        wr;

	assign age      = cmd.now - time_q;
	assign expired  = age >= cmd.ttl;
	assign match    = valid_q && orig_q == cmd.orig && req_q == cmd.req && tgt_q == cmd.tgt;
	assign scan     = tok_q.active && !tok_q.fill;
	assign first    = scan && match && !tok_q.hit;
	assign is_free  = !valid_q || expired;
	assign fill_hit = tok_q.active && tok_q.fill && !tok_q.done && time_q == tok_q.old_time;
	assign wr       = (cmd.wr_free && free_mark_q) || fill_hit;

	always_comb begin
		tok_out = tok_q;
		if (scan) begin
			tok_out.hit        = tok_q.hit | match;
			tok_out.free_found = tok_q.free_found | is_free;
			if (first) begin
				tok_out.live = !expired;
			end
			if (!tok_q.have_old || time_q < tok_q.old_time) begin
				tok_out.old_time = time_q;
				tok_out.have_old = 1'b1;
			end
		end
		if (fill_hit) begin
			tok_out.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= '0;
			valid_q     <= 1'b0;
			time_q      <= '0;
			free_mark_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (scan) begin
				free_mark_q <= is_free && !tok_q.free_found;
			end
			if (wr) begin
				valid_q <= 1'b1;
				time_q  <= cmd.now;
			end else if (first && expired) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			orig_q <= cmd.orig;
			req_q  <= cmd.req;
			tgt_q  <= cmd.tgt;
		end
	end
endmodule

// ----- design/rrd_rev_cell.sv -----
`timescale 1ns / 1ps
module rrd_rev_cell #(
	parameter bit IS_SLOT0 = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rrd_pkg::rev_cmd_t cmd,
	input  rrd_pkg::rev_tok_t tok_in,
	output rrd_pkg::rev_tok_t tok_out
);
	import rrd_pkg::*;

	logic        valid_q;
	logic [63:0] orig_q;
	logic [31:0] req_q;
	logic [63:0] prev_q;
	logic [31:0] time_q;
	logic        free_mark_q;
	logic        hit_mark_q;
	rev_tok_t    tok_q;

	logic [31:0] age;
	logic        expired;
	logic        match;
	logic        first;
	logic        is_free;
	logic        wr;

	assign age     = cmd.now - time_q;
	assign expired = age >= cmd.ttl;
	assign match   = valid_q && orig_q == cmd.orig && req_q == cmd.req;
	assign first   = tok_q.active && match && !tok_q.hit;
	assign is_free = !valid_q || expired;
	assign wr      = (cmd.wr_free && free_mark_q) || (cmd.wr_zero && IS_SLOT0);

	always_comb begin
		tok_out = tok_q;
		if (tok_q.active) begin
			tok_out.hit        = tok_q.hit | match;
			tok_out.free_found = tok_q.free_found | is_free;
			if (first) begin
				tok_out.live     = !expired;
				tok_out.prev_hop = prev_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= '0;
			valid_q     <= 1'b0;
			free_mark_q <= 1'b0;
			hit_mark_q  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (tok_q.active) begin
				free_mark_q <= is_free && !tok_q.free_found;
				hit_mark_q  <= first && !expired;
			end
			if (wr) begin
				valid_q <= 1'b1;
			end else if ((first && expired) || (cmd.clr_hit && hit_mark_q)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			orig_q <= cmd.orig;
			req_q  <= cmd.req;
			prev_q <= cmd.prev;
			time_q <= cmd.now;
		end
	end
endmodule

// ----- tb/route_request_dedup_reverse_path_top_test.sv -----
`timescale 1ns / 1ps
module route_request_dedup_reverse_path_top_test;
	import rrd_pkg::*;

	localparam int NSEEN = 32;
	localparam int NREV = 16;
	localparam int SETTLE = 150;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic        func;
		logic [31:0] now_ms;
		logic [63:0] from_id;
		logic [63:0] target_id;
		logic [31:0] req_id;
		logic [7:0]  hop_count;
		logic [63:0] peer_id;
		logic [7:0]  payload_len;
		logic        for_me;
	} route_pkt_t;

	typedef struct {
		act_t        action;
		logic [63:0] dest_id;
		logic [7:0]  hop_count_out;
		logic [4:0]  forward_ttl;
		logic [63:0] origin_id;
	} route_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rrd_in_if  req_ch();
	rrd_out_if res_ch();
	rrd_cfg_if cfg_ch();

	route_request_dedup_reverse_path_top dut (
		.clk(clk), .arst_n(arst_n), .request(req_ch.sink), .result(res_ch.source),
		.cfg(cfg_ch.sink)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the block state.
	logic [31:0] seen_life, rev_life;
	logic        seen_v[NSEEN];
	logic [63:0] seen_o[NSEEN];
	logic [31:0] seen_r[NSEEN];
	logic [63:0] seen_g[NSEEN];
	logic [31:0] seen_t[NSEEN];
	logic        rev_v[NREV];
	logic [63:0] rev_o[NREV];
	logic [31:0] rev_r[NREV];
	logic [63:0] rev_p[NREV];
	logic [31:0] rev_t[NREV];

	route_verdict_t pending_verdicts[$];
	int fail_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int action_hits[7];
	logic [31:0] clock_ms;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.func = 1'b0;
		req_ch.now_ms = '0;
		req_ch.from_id = '0;
		req_ch.target_id = '0;
		req_ch.req_id = '0;
		req_ch.hop_count = '0;
		req_ch.peer_id = '0;
		req_ch.payload_len = '0;
		req_ch.for_me = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SEEN_TTL;
		cfg_ch.data = '0;
	end

	function automatic logic seen_is_dup(logic [63:0] o, logic [31:0] r, logic [63:0] g,
		logic [31:0] now);
		for (int i = 0; i < NSEEN; i++) begin
			if (seen_v[i] && seen_o[i] == o && seen_r[i] == r && seen_g[i] == g) begin
				if (32'(now - seen_t[i]) < seen_life) return 1'b1;
				seen_v[i] = 1'b0;
				return 1'b0;
			end
		end
		return 1'b0;
	endfunction

	function automatic void seen_record(logic [63:0] o, logic [31:0] r, logic [63:0] g,
		logic [31:0] now);
		int slot;
		logic [31:0] oldest;
		slot = -1;
		for (int i = 0; i < NSEEN; i++) begin
			if (slot < 0 && (!seen_v[i] || 32'(now - seen_t[i]) >= seen_life)) slot = i;
		end
		if (slot < 0) begin
			slot = 0;
			oldest = seen_t[0];
			for (int i = 1; i < NSEEN; i++) begin
				if (seen_t[i] < oldest) begin
					oldest = seen_t[i];
					slot = i;
				end
			end
		end
		seen_o[slot] = o;
		seen_r[slot] = r;
		seen_g[slot] = g;
		seen_t[slot] = now;
		seen_v[slot] = 1'b1;
	endfunction

	function automatic int rev_find(logic [63:0] o, logic [31:0] r, logic [31:0] now);
		for (int i = 0; i < NREV; i++) begin
			if (rev_v[i] && rev_o[i] == o && rev_r[i] == r) begin
				if (32'(now - rev_t[i]) < rev_life) return i;
				rev_v[i] = 1'b0;
				return -1;
			end
		end
		return -1;
	endfunction

	function automatic void rev_record(logic [63:0] o, logic [31:0] r, logic [63:0] p,
		logic [31:0] now);
		int slot;
		slot = -1;
		if (rev_find(o, r, now) >= 0) return;
		for (int i = 0; i < NREV; i++) begin
			if (slot < 0 && (!rev_v[i] || 32'(now - rev_t[i]) >= rev_life)) slot = i;
		end
		if (slot < 0) slot = 0;
		rev_o[slot] = o;
		rev_r[slot] = r;
		rev_p[slot] = p;
		rev_t[slot] = now;
		rev_v[slot] = 1'b1;
	endfunction

	function automatic route_verdict_t route_decide(route_pkt_t p);
		route_verdict_t v;
		int idx;
		int nh;
		v.action = ACT_SHORT;
		v.dest_id = '0;
		v.hop_count_out = '0;
		v.forward_ttl = MAX_TTL;
		v.origin_id = p.from_id;
		if (p.payload_len < MIN_PAYLOAD) begin
			v.action = ACT_SHORT;
		end else if (p.func == 1'b0) begin
			if (seen_is_dup(p.from_id, p.req_id, p.target_id, p.now_ms)) begin
				v.action = ACT_DUP;
			end else begin
				seen_record(p.from_id, p.req_id, p.target_id, p.now_ms);
				v.hop_count_out = p.hop_count + 8'd1;
				if (p.for_me) begin
					v.action = ACT_REPLY;
					v.dest_id = p.peer_id;
				end else begin
					nh = int'(p.hop_count) + 1;
					rev_record(p.from_id, p.req_id, p.peer_id, p.now_ms);
					v.action = ACT_FORWARD;
					v.forward_ttl = (nh >= 31) ? 5'd0 : 5'(31 - nh);
				end
			end
		end else if (p.for_me) begin
			v.action = ACT_LOCAL;
		end else begin
			idx = rev_find(p.peer_id, p.req_id, p.now_ms);
			if (idx < 0) begin
				v.action = ACT_NOREV;
			end else begin
				v.action = ACT_RELAY;
				v.dest_id = rev_p[idx];
				v.hop_count_out = p.hop_count;
				rev_v[idx] = 1'b0;
			end
		end
		return v;
	endfunction

	task automatic send_packet(route_pkt_t p);
		logic taken;
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= p.func;
		req_ch.now_ms <= p.now_ms;
		req_ch.from_id <= p.from_id;
		req_ch.target_id <= p.target_id;
		req_ch.req_id <= p.req_id;
		req_ch.hop_count <= p.hop_count;
		req_ch.peer_id <= p.peer_id;
		req_ch.payload_len <= p.payload_len;
		req_ch.for_me <= p.for_me;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end while (!taken);
		pending_verdicts.push_back(route_decide(p));
		sent_count++;
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		logic taken;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do begin
			@(negedge clk);
			taken = cfg_ch.ready;
			@(posedge clk);
		end while (!taken);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_SEEN_TTL) seen_life = val;
		else rev_life = val;
	endtask

	always @(posedge clk) res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(negedge clk) begin
		route_verdict_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			checked_count++;
			if (pending_verdicts.size() == 0) begin
				$error("result item arrived with none expected");
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				action_hits[want.action]++;
				if (res_ch.action !== want.action) begin
					$error("action: expected %0d, got %0d", want.action, res_ch.action);
					fail_count++;
				end
				if (res_ch.dest_id !== want.dest_id) begin
					$error("dest_id: expected %h, got %h", want.dest_id, res_ch.dest_id);
					fail_count++;
				end
				if (res_ch.hop_count_out !== want.hop_count_out) begin
					$error("hop_count_out: expected %0d, got %0d", want.hop_count_out,
						res_ch.hop_count_out);
					fail_count++;
				end
				if (res_ch.forward_ttl !== want.forward_ttl) begin
					$error("forward_ttl: expected %0d, got %0d", want.forward_ttl,
						res_ch.forward_ttl);
					fail_count++;
				end
				if (res_ch.origin_id !== want.origin_id) begin
					$error("origin_id: expected %h, got %h", want.origin_id,
						res_ch.origin_id);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(negedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_verdicts.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic route_pkt_t make_pkt(logic func, logic [63:0] from, logic [63:0] tgt,
		logic [31:0] rid, logic [7:0] hops, logic [63:0] peer, logic [7:0] plen,
		logic me);
		route_pkt_t p;
		p.func = func;
		p.now_ms = clock_ms;
		p.from_id = from;
		p.target_id = tgt;
		p.req_id = rid;
		p.hop_count = hops;
		p.peer_id = peer;
		p.payload_len = plen;
		p.for_me = me;
		return p;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_basic_actions();
		send_packet(make_pkt(1'b0, 64'h11, 64'h22, 32'd1, 8'd0, 64'h33, 8'd0, 1'b0));
		send_packet(make_pkt(1'b1, 64'h11, 64'h22, 32'd1, 8'd0, 64'h33, 8'd20, 1'b0));
		send_packet(make_pkt(1'b0, 64'h11, 64'h22, 32'd1, 8'd0, 64'h33, 8'd21, 1'b0));
		send_packet(make_pkt(1'b0, 64'h11, 64'h22, 32'd1, 8'd0, 64'h33, 8'd255, 1'b0));
		send_packet(make_pkt(1'b0, '1, '1, '1, 8'd255, '1, 8'd40, 1'b1));
		send_packet(make_pkt(1'b0, 64'h44, 64'h55, 32'd2, 8'd29, 64'h66, 8'd30, 1'b0));
		send_packet(make_pkt(1'b0, 64'h44, 64'h55, 32'd3, 8'd30, 64'h66, 8'd30, 1'b0));
		send_packet(make_pkt(1'b0, 64'h44, 64'h55, 32'd4, 8'd31, 64'h66, 8'd30, 1'b0));
		send_packet(make_pkt(1'b0, 64'h44, 64'h55, 32'd5, 8'd255, 64'h66, 8'd30, 1'b0));
		send_packet(make_pkt(1'b1, 64'h77, 64'h0, 32'd1, 8'd3, 64'h11, 8'd30, 1'b1));
		send_packet(make_pkt(1'b1, 64'h77, 64'h0, 32'd1, 8'd7, 64'h11, 8'd30, 1'b0));
		send_packet(make_pkt(1'b1, 64'h77, 64'h0, 32'd1, 8'd7, 64'h11, 8'd30, 1'b0));
		send_packet(make_pkt(1'b1, '1, '1, '1, 8'd255, 64'h44, 8'd30, 1'b0));
	endtask

	task automatic test_expiry();
		// A short lifetime lets the same request expire and come back as new.
		write_reg(CFG_SEEN_TTL, 32'd1);
		write_reg(CFG_REV_TTL, 32'd1);
		clock_ms = 32'd5000;
		send_packet(make_pkt(1'b0, 64'h90, 64'h91, 32'd9, 8'd1, 64'h92, 8'd25, 1'b0));
		send_packet(make_pkt(1'b0, 64'h90, 64'h91, 32'd9, 8'd1, 64'h92, 8'd25, 1'b0));
		clock_ms = 32'd5001;
		send_packet(make_pkt(1'b0, 64'h90, 64'h91, 32'd9, 8'd1, 64'h93, 8'd25, 1'b0));
		clock_ms = 32'd5002;
		send_packet(make_pkt(1'b1, 64'h94, 64'h0, 32'd9, 8'd1, 64'h90, 8'd25, 1'b0));
		write_reg(CFG_SEEN_TTL, 32'hFFFF_FFFF);
		write_reg(CFG_REV_TTL, 32'hFFFF_FFFF);
	endtask

	task automatic test_tables_full();
		// More distinct requests than either table holds forces replacement.
		for (int i = 0; i < 36; i++) begin
			clock_ms = 32'd100 + 32'(i * 7 % 13);
			send_packet(make_pkt(1'b0, 64'(i), 64'hA0, 32'd77, 8'd2, 64'(1000 + i), 8'd30,
				1'b0));
		end
		send_packet(make_pkt(1'b1, 64'h5, 64'h0, 32'd77, 8'd2, 64'd0, 8'd30, 1'b0));
		send_packet(make_pkt(1'b1, 64'h5, 64'h0, 32'd77, 8'd2, 64'd35, 8'd30, 1'b0));
		send_packet(make_pkt(1'b0, 64'd35, 64'hA0, 32'd77, 8'd2, 64'd1, 8'd30, 1'b0));
	endtask

	task automatic test_random_traffic(int count);
		route_pkt_t p;
		logic [63:0] nodes[8];
		for (int k = 0; k < 8; k++) nodes[k] = rand64();
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0) clock_ms += $urandom;
			else clock_ms += $urandom_range(0, 40);
			if ($urandom_range(19) == 0) nodes[3'($urandom_range(7))] = rand64();
			if ($urandom_range(9) == 0) begin
				p = make_pkt(1'($urandom_range(1)), rand64(), rand64(), $urandom,
					8'($urandom), rand64(), 8'($urandom), 1'($urandom_range(1)));
			end else if ($urandom_range(1) == 0) begin
				p = make_pkt(1'b0, nodes[3'($urandom_range(7))], nodes[2'($urandom_range(3))],
					32'($urandom_range(5)), 8'($urandom_range(40)),
					nodes[3'($urandom_range(7))], 8'($urandom_range(21, 255)),
					($urandom_range(5) == 0));
			end else begin
				p = make_pkt(1'b1, nodes[3'($urandom_range(7))], nodes[2'($urandom_range(3))],
					32'($urandom_range(5)), 8'($urandom), nodes[3'($urandom_range(7))],
					8'($urandom_range(21, 255)), ($urandom_range(7) == 0));
			end
			if ($urandom_range(19) == 0) p.payload_len = 8'($urandom_range(20));
			send_packet(p);
		end
	endtask

	initial begin
		seen_life = SEEN_TTL_RST;
		rev_life = REV_TTL_RST;
		clock_ms = 32'd0;
		foreach (seen_v[i]) seen_v[i] = 1'b0;
		foreach (seen_t[i]) seen_t[i] = '0;
		foreach (rev_v[i]) rev_v[i] = 1'b0;
		foreach (action_hits[i]) action_hits[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_actions();
		test_expiry();
		test_tables_full();

		send_idle_pct = 36;
		recv_stall_pct = 61;
		write_reg(CFG_SEEN_TTL, 32'd30000);
		write_reg(CFG_REV_TTL, 32'd60000);
		clock_ms = 32'hFFFF_F000;
		test_random_traffic(640);

		send_idle_pct = 61;
		recv_stall_pct = 36;
		write_reg(CFG_SEEN_TTL, 32'd90);
		write_reg(CFG_REV_TTL, 32'hFFFF_FFFF);
		test_random_traffic(640);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(CFG_SEEN_TTL, 32'hFFFF_FFFF);
		write_reg(CFG_REV_TTL, 32'd60);
		test_random_traffic(640);

		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d route items sent, %0d results checked under three lifetime settings",
			sent_count, checked_count);
		$display("actions short/dup/reply/fwd/local/norev/relay: %0d %0d %0d %0d %0d %0d %0d",
			action_hits[0], action_hits[1], action_hits[2], action_hits[3], action_hits[4],
			action_hits[5], action_hits[6]);
		if (fail_count == 0 && pending_verdicts.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
